/* hw/rtl/swpl_pkg.sv */
package swpl_pkg;

  // window geometry
  localparam int MAX_POINTS = 100;
  localparam int RING_DEPTH = MAX_POINTS - 2;
  localparam int HEAD_W     = $clog2(RING_DEPTH);
  localparam int COUNT_W    = $clog2(MAX_POINTS);

  // field widths
  localparam int COORD_W = 16;
  localparam int PATH_W  = 24;
  localparam int KEPT_W  = 7;

  // segment arithmetic: |d| fits 16 bits, sum of squares 33 bits, root 17 bits
  localparam int ABS_W    = 16;
  localparam int SUMSQ_W  = 2 * ABS_W + 1;
  localparam int ROOT_W   = 17;
  localparam int SEG_MAX  = 92681;
  localparam int TOTAL_W  = $clog2(RING_DEPTH * SEG_MAX + 1);
  localparam int SAT_W    = (TOTAL_W > PATH_W) ? TOTAL_W : PATH_W;
  localparam logic [PATH_W-1:0] LEN_MAX = '1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
  } point_t;

  typedef struct packed {
    logic [PATH_W-1:0] path_length;
    logic [KEPT_W-1:0] points_kept;
  } result_t;

  // handshake between the sequencer and the square root unit
  typedef struct packed {
    logic busy;
    logic done;
  } root_status_t;

endpackage

/* hw/rtl/swpl_ram.sv */
module swpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/swpl_isqrt.sv */
module swpl_isqrt (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [swpl_pkg::SUMSQ_W-1:0]         radicand,
  output logic [swpl_pkg::ROOT_W-1:0]          root,
  output swpl_pkg::root_status_t               status
);

  localparam int RAD_W = 2 * swpl_pkg::ROOT_W;
  localparam int REM_W = swpl_pkg::ROOT_W + 4;
  localparam int CNT_W = $clog2(swpl_pkg::ROOT_W);

  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  // one result bit per cycle: bring down two radicand bits, try root*4+1
  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[RAD_W-1:RAD_W-2]};
    trial  = REM_W'({root, 2'b01});
    fits   = (rem_sh >= trial);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(swpl_pkg::ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= RAD_W'(radicand);
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (fits) begin
        rem  <= rem_sh - trial;
        root <= {root[swpl_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[swpl_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

/* hw/rtl/sliding_window_path_length.sv */
// flow: an accepted point passes the squaring, root start, root wait, add and done
//   states before its result word is registered (the first point after reset goes
//   straight to done), dominated by the bit-serial square root; a new point is taken
//   only in idle, so one shared 16x16 squarer and one square root unit serve each point in turn
// reset: synchronous, active high; clears the window, the sum and the last point,
//   the segment ring needs no clearing since each slot is written before it is read
module sliding_window_path_length (
  input  logic              clk,
  input  logic              rst,
  input  logic              point_valid,
  output logic              point_ready,
  input  swpl_pkg::point_t  point,
  output logic              result_valid,
  input  logic              result_ready,
  output swpl_pkg::result_t result
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SQX   = 7'b0000010,
    S_SQY   = 7'b0000100,
    S_START = 7'b0001000,
    S_ROOT  = 7'b0010000,
    S_ADD   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;

  logic signed [swpl_pkg::COORD_W-1:0] prev_x;
  logic signed [swpl_pkg::COORD_W-1:0] prev_y;
  logic [swpl_pkg::COUNT_W-1:0]        point_count;
  logic [swpl_pkg::HEAD_W-1:0]         ring_head;
  logic [swpl_pkg::TOTAL_W-1:0]        running_total;
  logic [swpl_pkg::ABS_W-1:0]          abs_x;
  logic [swpl_pkg::ABS_W-1:0]          abs_y;
  logic [swpl_pkg::SUMSQ_W-1:0]        sumsq;

  logic                                accept;
  logic                                full;
  logic [swpl_pkg::COORD_W:0]          dx;
  logic [swpl_pkg::COORD_W:0]          dy;
  logic [swpl_pkg::COORD_W:0]          dx_abs;
  logic [swpl_pkg::COORD_W:0]          dy_abs;
  logic [swpl_pkg::ABS_W-1:0]          mul_a;
  logic [2*swpl_pkg::ABS_W-1:0]        product;
  logic [swpl_pkg::SAT_W-1:0]          total_wide;
  logic [swpl_pkg::ROOT_W-1:0]         seg;
  logic [swpl_pkg::ROOT_W-1:0]         old_seg;
  swpl_pkg::root_status_t              root_status;

  assign point_ready = (state == S_IDLE);
  assign accept      = point_valid && point_ready;
  assign full        = (point_count == swpl_pkg::COUNT_W'(swpl_pkg::MAX_POINTS - 1));

  // differences to the previous point and their magnitudes
  always_comb begin
    dx     = {point.x_coord[swpl_pkg::COORD_W-1], point.x_coord}
             - {prev_x[swpl_pkg::COORD_W-1], prev_x};
    dy     = {point.y_coord[swpl_pkg::COORD_W-1], point.y_coord}
             - {prev_y[swpl_pkg::COORD_W-1], prev_y};
    dx_abs = dx[swpl_pkg::COORD_W] ? ('0 - dx) : dx;
    dy_abs = dy[swpl_pkg::COORD_W] ? ('0 - dy) : dy;
  end

  // shared squarer: x in one cycle, y in the next
  assign mul_a   = (state == S_SQX) ? abs_x : abs_y;
  assign product = mul_a * mul_a;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (point_count == '0) ? S_DONE : S_SQX;
          end
        end
        S_SQX:   state <= S_SQY;
        S_SQY:   state <= S_START;
        S_START: state <= S_ROOT;
        S_ROOT: begin
          if (root_status.done) begin
            state <= S_ADD;
          end
        end
        S_ADD:   state <= S_DONE;
        S_DONE: begin
          if (!result_valid || result_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x        <= '0;
      prev_y        <= '0;
      point_count   <= '0;
      ring_head     <= '0;
      running_total <= '0;
    end else begin
      if (accept) begin
        prev_x <= point.x_coord;
        prev_y <= point.y_coord;
        if (point_count == '0) begin
          point_count <= swpl_pkg::COUNT_W'(1);
        end
      end
      // oldest segment leaves the sum once the window is full
      if (state == S_SQY && full) begin
        running_total <= running_total - swpl_pkg::TOTAL_W'(old_seg);
      end
      if (state == S_ADD) begin
        running_total <= running_total + swpl_pkg::TOTAL_W'(seg);
        if (!full) begin
          point_count <= point_count + 1'b1;
        end
        if (ring_head == swpl_pkg::HEAD_W'(swpl_pkg::RING_DEPTH - 1)) begin
          ring_head <= '0;
        end else begin
          ring_head <= ring_head + 1'b1;
        end
      end
    end
  end

  // segment operands
  always_ff @(posedge clk) begin
    if (accept) begin
      abs_x <= dx_abs[swpl_pkg::ABS_W-1:0];
      abs_y <= dy_abs[swpl_pkg::ABS_W-1:0];
    end
    if (state == S_SQX) begin
      sumsq <= swpl_pkg::SUMSQ_W'(product);
    end else if (state == S_SQY) begin
      sumsq <= sumsq + swpl_pkg::SUMSQ_W'(product);
    end
  end

  swpl_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_START),
    .radicand (sumsq),
    .root     (seg),
    .status   (root_status)
  );

  // ring of segment lengths, oldest slot read while squaring
  swpl_ram #(
    .WIDTH (swpl_pkg::ROOT_W),
    .DEPTH (swpl_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (state == S_ADD),
    .waddr (ring_head),
    .wdata (seg),
    .raddr (ring_head),
    .rdata (old_seg)
  );

  // output word register
  assign total_wide = swpl_pkg::SAT_W'(running_total);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && (!result_valid || result_ready)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!result_valid || result_ready)) begin
      result.path_length <= (total_wide > swpl_pkg::SAT_W'(swpl_pkg::LEN_MAX))
                            ? swpl_pkg::LEN_MAX
                            : swpl_pkg::PATH_W'(total_wide);
      result.points_kept <= swpl_pkg::KEPT_W'(point_count);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= swpl_pkg::COUNT_W'(swpl_pkg::MAX_POINTS - 1))
    else $error("window holds too many points");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    ring_head <= swpl_pkg::HEAD_W'(swpl_pkg::RING_DEPTH - 1))
    else $error("ring head out of range");

  a_root_done: assert property (@(posedge clk) disable iff (rst)
    root_status.done |-> (state == S_ROOT))
    else $error("square root finished outside its wait state");

  a_root_busy: assert property (@(posedge clk) disable iff (rst)
    root_status.busy |-> (state == S_ROOT))
    else $error("square root running outside its wait state");

  a_empty_total: assert property (@(posedge clk) disable iff (rst)
    (point_count <= swpl_pkg::COUNT_W'(1)) |-> (running_total == '0))
    else $error("nonzero length with fewer than two points");
`endif

endmodule
